// ----- rtl/core/sef_pkg.sv -----
package sef_pkg;

  // Default widths of the sample and position fields
  localparam int SAMPLE_BITS_DEF   = 32;
  localparam int POSITION_BITS_DEF = 16;

  // Depth of the result queue; two free slots are needed to take a beat
  localparam int RESULT_DEPTH = 4;

  // Write controls from the detector into the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } sef_push_t;

endpackage

// ----- rtl/core/sef_detector.sv -----
module sef_detector #(
  parameter int SAMPLE_BITS   = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last_sample,
  output sef_pkg::sef_push_t            push,
  output logic [POSITION_BITS+1:0]      res0,
  output logic [POSITION_BITS+1:0]      res1
);
  import sef_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic [POSITION_BITS-1:0]      cnt_r;
  logic                          have_prev_r;
  logic                          have_dir_r;
  logic                          rising_r;
  logic                          mode_r;

  logic                          changed;
  logic                          rising;
  logic                          turn;
  logic                          e_mid;
  logic                          e_end;
  logic                          dir_now;
  logic                          rise_now;
  logic [POSITION_BITS-1:0]      cur_pos;
  logic [POSITION_BITS+1:0]      mid_item;
  logic [POSITION_BITS+1:0]      end_item;
  logic [POSITION_BITS+1:0]      marker_item;

  // Compare against the previous sample and find a direction turn
  always_comb begin
    changed  = have_prev_r && (sample != prev_r);
    rising   = sample > prev_r;
    if (have_dir_r) begin
      turn = mode_r ? (!rising_r && rising) : (rising_r && !rising);
    end else begin
      turn = mode_r && rising;
    end
    e_mid    = changed && turn;
    dir_now  = have_dir_r || changed;
    rise_now = changed ? rising : rising_r;
    e_end    = last_sample && mode_r && dir_now && !rise_now && !e_mid;
    if (!have_prev_r) begin
      cur_pos = '0;
    end else if (cnt_r == POS_MAX) begin
      cur_pos = POS_MAX;
    end else begin
      cur_pos = cnt_r + POSITION_BITS'(1);
    end
  end

  // Build result beats: extremum first, end marker after it
  always_comb begin
    mid_item    = {cnt_r, 1'b1, 1'b0};
    end_item    = {cur_pos, 1'b1, 1'b0};
    marker_item = {{POSITION_BITS{1'b0}}, 1'b0, 1'b1};
    res1        = marker_item;
    push.push0  = 1'b0;
    push.push1  = 1'b0;
    if (e_mid) begin
      res0       = mid_item;
      push.push0 = accept;
      push.push1 = accept && last_sample;
    end else if (e_end) begin
      res0       = end_item;
      push.push0 = accept;
      push.push1 = accept;
    end else begin
      res0       = marker_item;
      push.push0 = accept && last_sample;
    end
  end

  // Hold mode and per-signal state; clear state on the final sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      prev_r      <= '0;
      cnt_r       <= '0;
      have_prev_r <= 1'b0;
      have_dir_r  <= 1'b0;
      rising_r    <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mode_r <= cfg_write_data;
      end
      if (accept) begin
        if (last_sample) begin
          prev_r      <= '0;
          cnt_r       <= '0;
          have_prev_r <= 1'b0;
          have_dir_r  <= 1'b0;
          rising_r    <= 1'b0;
        end else begin
          prev_r      <= sample;
          cnt_r       <= cur_pos;
          have_prev_r <= 1'b1;
          have_dir_r  <= dir_now;
          rising_r    <= rise_now;
        end
      end
    end
  end

endmodule

// ----- rtl/core/sef_result_fifo.sv -----
module sef_result_fifo #(
  parameter int ENTRY_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sef_pkg::sef_push_t    push,
  input  logic [ENTRY_BITS-1:0] wr_data0,
  input  logic [ENTRY_BITS-1:0] wr_data1,
  input  logic                  pop,
  output logic                  space_ok,
  output logic                  not_empty,
  output logic [ENTRY_BITS-1:0] rd_data
);
  import sef_pkg::*;

  localparam int PW = $clog2(RESULT_DEPTH);
  localparam int CW = $clog2(RESULT_DEPTH + 1);
  localparam logic [CW-1:0] SPACE_LIMIT = CW'(RESULT_DEPTH - 2);

  logic [ENTRY_BITS-1:0] mem_r [RESULT_DEPTH];
  logic [PW-1:0]         wr_r;
  logic [PW-1:0]         wr_nxt;
  logic [PW-1:0]         rd_r;
  logic [PW-1:0]         rd_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  do_pop;

  // Status from the registered count only
  assign space_ok  = count_r <= SPACE_LIMIT;
  assign not_empty = count_r != '0;
  assign rd_data   = mem_r[rd_r];
  assign do_pop    = pop && not_empty;

  // Advance pointers and count
  always_comb begin
    wr_nxt    = wr_r + PW'(push.push0) + PW'(push.push1);
    rd_nxt    = rd_r + PW'(do_pop);
    count_nxt = count_r + CW'(push.push0) + CW'(push.push1) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Store up to two beats per cycle
  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_r] <= wr_data0;
    end
    if (push.push1) begin
      mem_r[wr_r + PW'(1)] <= wr_data1;
    end
  end

endmodule

// ----- rtl/core/signal_extrema_finder_unit.sv -----
// Channel | Ports                                            | Beat taken when
// --------+--------------------------------------------------+--------------------
// in      | in_valid, in_stall, in_sample, in_last_sample    | in_valid & !in_stall
// out     | out_valid, out_stall, out_position, out_found,   | out_valid & !out_stall
//         | out_end_of_signal                                |
// cfg     | cfg_write_en, cfg_write_data                     | cfg_write_en
//
// One input beat per cycle while in_stall is low; the compare and state update finish in the accept cycle.
// Results land in a four-entry queue; out_valid comes from the queue's registered count.
// A final sample may produce two result beats; out drains one beat per cycle while out_stall is low.
// in_stall rises when the queue has fewer than two free entries.
// Synchronous active-low reset clears mode, signal state and the queue.
module signal_extrema_finder_unit #(
  parameter int SAMPLE_BITS   = sef_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = sef_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [POSITION_BITS-1:0]      out_position,
  output logic                          out_found,
  output logic                          out_end_of_signal
);
  import sef_pkg::*;

  localparam int ENTRY_BITS = POSITION_BITS + 2;

  logic                  accept;
  logic                  space_ok;
  sef_push_t             push;
  logic [ENTRY_BITS-1:0] res0;
  logic [ENTRY_BITS-1:0] res1;
  logic [ENTRY_BITS-1:0] head;

  // Take a beat only with room for two results
  assign in_stall = !space_ok;
  assign accept   = in_valid && space_ok;

  sef_detector #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_detector (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .accept        (accept),
    .sample        (in_sample),
    .last_sample   (in_last_sample),
    .push          (push),
    .res0          (res0),
    .res1          (res1)
  );

  sef_result_fifo #(
    .ENTRY_BITS(ENTRY_BITS)
  ) u_result_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data0 (res0),
    .wr_data1 (res1),
    .pop      (!out_stall),
    .space_ok (space_ok),
    .not_empty(out_valid),
    .rd_data  (head)
  );

  // Unpack the head beat
  assign out_position      = head[ENTRY_BITS-1:2];
  assign out_found         = head[1];
  assign out_end_of_signal = head[0];

endmodule

// ----- tb/sv/signal_extrema_finder_checker.sv -----
`timescale 1ns / 1ps

module signal_extrema_finder_checker #(
  parameter int SAMPLE_BITS   = sef_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = sef_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [POSITION_BITS-1:0]      out_position,
  input  logic                          out_found,
  input  logic                          out_end_of_signal,
  output int                            mismatches,
  output int                            pending
);

  typedef struct packed {
    logic [POSITION_BITS-1:0] position;
    logic                     found;
    logic                     end_of_signal;
  } extremum_t;

  // Results still owed by the block, oldest first
  extremum_t expected_extrema[$];

  // Mirror of the mode register and of the per-signal tracking state
  logic                          valley_mode;
  logic signed [SAMPLE_BITS-1:0] last_value;
  logic [POSITION_BITS-1:0]      position_count;
  logic                          seen_sample;
  logic                          seen_change;
  logic                          last_rising;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Append one owed result at the tail
  task automatic queue_expected(input extremum_t item);
    expected_extrema = {expected_extrema, item};
  endtask

  task automatic clear_tracking();
    last_value     = '0;
    position_count = '0;
    seen_sample    = 1'b0;
    seen_change    = 1'b0;
    last_rising    = 1'b0;
  endtask

  // Work out the results one input beat causes and queue them
  task automatic predict_extrema(input logic signed [SAMPLE_BITS-1:0] value,
                                 input logic closing);
    logic [POSITION_BITS-1:0] next_position;
    logic                     rising;
    logic                     turn;
    int                       emitted;
    next_position = '0;
    emitted       = 0;
    // Advance the position, holding it once it saturates
    if (seen_sample) begin
      next_position = (&position_count) ? position_count : position_count + 1'b1;
    end
    // Flat steps carry no direction; only a change can mark a turn
    if (seen_sample && value != last_value) begin
      rising = value > last_value;
      if (seen_change) begin
        turn = valley_mode ? (!last_rising && rising) : (last_rising && !rising);
      end else begin
        // A first rise marks the start as a valley
        turn = valley_mode && rising;
      end
      if (turn) begin
        queue_expected({position_count, 1'b1, 1'b0});
        emitted++;
      end
      seen_change = 1'b1;
      last_rising = rising;
    end
    last_value     = value;
    position_count = next_position;
    seen_sample    = 1'b1;
    // Close the signal: in valley mode a trailing fall is a valley, then the end marker
    if (closing) begin
      if (valley_mode && seen_change && !last_rising && emitted == 0) begin
        queue_expected({next_position, 1'b1, 1'b0});
      end
      queue_expected({{POSITION_BITS{1'b0}}, 1'b0, 1'b1});
      clear_tracking();
    end
  endtask

  // Compare result beats first, then take the input beat, then the register write
  always @(posedge clk) begin : watch_channels
    extremum_t want;
    if (!rst_n) begin
      mismatches  = 0;
      valley_mode = 1'b0;
      clear_tracking();
      expected_extrema.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_extrema.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending (position %0d)",
                                    out_position));
        end else begin
          want = expected_extrema.pop_front();
          if (out_position !== want.position) begin
            report_mismatch($sformatf("position got %0d want %0d",
                                      out_position, want.position));
          end
          if (out_found !== want.found) begin
            report_mismatch($sformatf("found got %0b want %0b", out_found, want.found));
          end
          if (out_end_of_signal !== want.end_of_signal) begin
            report_mismatch($sformatf("end_of_signal got %0b want %0b",
                                      out_end_of_signal, want.end_of_signal));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_extrema(in_sample, in_last_sample);
      end
      if (cfg_write_en) begin
        valley_mode = cfg_write_data;
      end
    end
    pending = expected_extrema.size();
  end

endmodule

// ----- tb/sv/signal_extrema_finder_unit_tb.sv -----
`timescale 1ns / 1ps

module signal_extrema_finder_unit_tb;
  import sef_pkg::*;

  localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
  localparam int POS_W         = POSITION_BITS_DEF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 200;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic {
    MODE_PEAKS   = 1'b0,
    MODE_VALLEYS = 1'b1
  } detect_mode_t;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_write_en   = 1'b0;
  logic                       cfg_write_data = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample      = '0;
  logic                       in_last_sample = 1'b0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic [POS_W-1:0]           out_position;
  logic                       out_found;
  logic                       out_end_of_signal;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches;
  int pending;
  int cycle_count   = 0;

  always #4 clk = ~clk;

  signal_extrema_finder_unit #(
    .SAMPLE_BITS   (SAMPLE_W),
    .POSITION_BITS (POS_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_found         (out_found),
    .out_end_of_signal (out_end_of_signal)
  );

  signal_extrema_finder_checker #(
    .SAMPLE_BITS   (SAMPLE_W),
    .POSITION_BITS (POS_W)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_found         (out_found),
    .out_end_of_signal (out_end_of_signal),
    .mismatches        (mismatches),
    .pending           (pending)
  );

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("signal_extrema_finder_unit_tb: done, errors");
    $finish;
  end

  // Offer one sample beat, with random idle cycles ahead of it; return at a falling edge
  task automatic send_beat(input logic signed [SAMPLE_W-1:0] value, input logic closing);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= value;
    in_last_sample <= closing;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  // Hold the sender until every owed result has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input detect_mode_t mode);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mode;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Mostly a narrow range so plateaus and turns are common
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] value;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        value = $urandom_range(6);
        value = value - 3;
      end
      6, 7: begin
        value = $urandom;
      end
      8: begin
        value = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      default: begin
        value = $urandom_range(1) ? SAMPLE_MAX - $urandom_range(2)
                                  : SAMPLE_MIN + $urandom_range(2);
      end
    endcase
    return value;
  endfunction

  // Send random signals until the beat budget is spent
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int items);
    int sent;
    int len;
    int k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    while (sent < items) begin
      case ($urandom_range(7))
        0:       len = 1;
        1:       len = $urandom_range(40, 13);
        default: len = $urandom_range(12, 2);
      endcase
      for (k = 0; k < len; k++) begin
        send_beat(random_sample(), k == len - 1);
        sent++;
        // Occasionally switch mode in the middle of a signal
        if (k != len - 1 && $urandom_range(49) == 0) begin
          drain_results();
          write_mode(detect_mode_t'($urandom_range(1)));
        end
      end
      if ($urandom_range(3) == 0) begin
        drain_results();
        write_mode(detect_mode_t'($urandom_range(1)));
      end
    end
    drain_results();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Peaks: extreme values with a plateau at the top
    write_mode(MODE_PEAKS);
    send_beat(SAMPLE_MIN, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MAX, 1'b0);
    send_beat(SAMPLE_MIN, 1'b1);
    // Single-sample and constant signals give only the marker
    send_beat(SAMPLE_MAX, 1'b1);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b0);
    send_beat(32'sd5, 1'b1);
    drain_results();

    // Valleys: rising start, inner valley on a plateau, falling end
    write_mode(MODE_VALLEYS);
    send_beat(32'sd3, 1'b0);
    send_beat(32'sd7, 1'b0);
    send_beat(32'sd7, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sd1, 1'b0);
    send_beat(32'sd9, 1'b0);
    send_beat(32'sd2, 1'b1);
    // Falling start, valley turn on the final sample
    send_beat(32'sd9, 1'b0);
    send_beat(-32'sd4, 1'b0);
    send_beat(32'sd0, 1'b1);
    send_beat(-32'sd1, 1'b1);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sd0, 1'b1);
    drain_results();

    run_random_phase(29, 86, PHASE_ITEMS);
    run_random_phase(86, 29, PHASE_ITEMS);
    run_random_phase(0, 0, PHASE_ITEMS);

    if (mismatches == 0) begin
      $display("signal_extrema_finder_unit_tb: done, clean");
    end else begin
      $display("signal_extrema_finder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sef_pkg.sv
rtl/core/sef_detector.sv
rtl/core/sef_result_fifo.sv
rtl/core/signal_extrema_finder_unit.sv
tb/sv/signal_extrema_finder_checker.sv
tb/sv/signal_extrema_finder_unit_tb.sv
